### src/brl_pkg.sv
// Shared types, constants and helpers for the Bresenham line rasterizer.
// Used by brl_core and bresenham_line_rasterizer; depends on nothing else.
package brl_pkg;

  // Coordinate width and error term width (two guard bits for sign and 2x).
  localparam int COORD_BITS = 12;
  localparam int DEC_W      = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DEC_W-1:0]      dec_t;

  // Command codes of an input item
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } line_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_out_t;

  // Move a coordinate one unit, wrapping at the coordinate width
  function automatic coord_t move_one(input coord_t v, input logic backward);
    move_one = backward ? (v - coord_t'(1)) : (v + coord_t'(1));
  endfunction

  // Absolute difference of two coordinates
  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### src/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: input register, line core, result register.
// Depends on brl_pkg and brl_core.
//
//   channel  | ports                            | payload
//   ---------+----------------------------------+------------------------------------
//   input    | in_valid, in_stall, in_data      | cmd, x_start, y_start, x_end, y_end
//   result   | out_valid, out_stall, out_data   | pixel_x, pixel_y, last_pixel
//
// One item per cycle while not stalled; an item is held in the input register, and its pixel
// then in the result register. Setup and every step are combinational logic in brl_core.
// rst_n is synchronous, active low, and leaves the block idle with no line.
// A stalled result holds the output register; the input register then fills and stalls.
// A step item with no line running is consumed and gives no result.
module bresenham_line_rasterizer
  import brl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  line_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pixel_out_t out_data
);

  logic       in_vld_r;
  line_in_t   in_data_r;
  logic       out_vld_r;
  pixel_out_t out_data_r;
  logic       advance;
  logic       go;
  logic       res_valid;
  pixel_out_t res;

  // Process the held item when the result register can take its pixel
  assign advance  = !out_vld_r || !out_stall;
  assign go       = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  brl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .cmd_in    (in_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Capture an item when the input register is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Load the pixel; hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= go && res_valid;
    end
    if (go && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A pixel comes only from a held item
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_vld_r))
    else $error("result without a held item");

  // A held item is never dropped while it stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r && $stable(in_data_r))
    else $error("stalled input item lost");

  // A stalled pixel stays in the result register
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(out_data_r))
    else $error("stalled pixel lost");
`endif

endmodule

### src/brl_core.sv
// Line state and combinational setup/step logic of the rasterizer.
// Depends on brl_pkg; instantiated by bresenham_line_rasterizer.
module brl_core
  import brl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  line_in_t   cmd_in,
  output logic       res_valid,
  output pixel_out_t res
);

  coord_t cur_x_r,  cur_x_nxt;
  coord_t cur_y_r,  cur_y_nxt;
  coord_t stop_x_r, stop_x_nxt;
  coord_t stop_y_r, stop_y_nxt;
  dec_t   decision_r, decision_nxt;
  coord_t delta_major_r, delta_major_nxt;
  coord_t delta_minor_r, delta_minor_nxt;
  logic   steep_r, steep_nxt;
  logic   x_backward_r, x_backward_nxt;
  logic   y_backward_r, y_backward_nxt;
  logic   busy_r, busy_nxt;

  coord_t dx;
  coord_t dy;
  logic   dy_gt_dx;
  logic   last;

  // Setup terms for a start item
  assign dx       = abs_diff(cmd_in.x_start, cmd_in.x_end);
  assign dy       = abs_diff(cmd_in.y_start, cmd_in.y_end);
  assign dy_gt_dx = dy > dx;

  // Start or step the line, then flag the pixel that reaches the end
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    stop_x_nxt      = stop_x_r;
    stop_y_nxt      = stop_y_r;
    decision_nxt    = decision_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    steep_nxt       = steep_r;
    x_backward_nxt  = x_backward_r;
    y_backward_nxt  = y_backward_r;
    busy_nxt        = busy_r;
    res_valid       = 1'b0;

    if (go) begin
      if (cmd_in.cmd == CMD_START) begin
        steep_nxt       = dy_gt_dx;
        delta_major_nxt = dy_gt_dx ? dy : dx;
        delta_minor_nxt = dy_gt_dx ? dx : dy;
        x_backward_nxt  = cmd_in.x_end < cmd_in.x_start;
        y_backward_nxt  = cmd_in.y_end < cmd_in.y_start;
        cur_x_nxt       = cmd_in.x_start;
        cur_y_nxt       = cmd_in.y_start;
        stop_x_nxt      = cmd_in.x_end;
        stop_y_nxt      = cmd_in.y_end;
        decision_nxt    = {1'b0, delta_minor_nxt, 1'b0} - {2'b00, delta_major_nxt};
        busy_nxt        = 1'b1;
        res_valid       = 1'b1;
      end else if (busy_r) begin
        // advance the major axis
        if (steep_r) begin
          cur_y_nxt = move_one(cur_y_r, y_backward_r);
        end else begin
          cur_x_nxt = move_one(cur_x_r, x_backward_r);
        end
        // advance the minor axis on a non-negative error term
        if (!decision_r[DEC_W-1]) begin
          if (steep_r) begin
            cur_x_nxt = move_one(cur_x_r, x_backward_r);
          end else begin
            cur_y_nxt = move_one(cur_y_r, y_backward_r);
          end
          decision_nxt = decision_r + {1'b0, delta_minor_r, 1'b0}
                         - {1'b0, delta_major_r, 1'b0};
        end else begin
          decision_nxt = decision_r + {1'b0, delta_minor_r, 1'b0};
        end
        res_valid = 1'b1;
      end
    end

    last = steep_nxt ? (cur_y_nxt == stop_y_nxt) : (cur_x_nxt == stop_x_nxt);
    if (res_valid && last) begin
      busy_nxt = 1'b0;
    end

    res.pixel_x    = cur_x_nxt;
    res.pixel_y    = cur_y_nxt;
    res.last_pixel = last;
  end

  // Hold line state; only busy needs a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    stop_x_r      <= stop_x_nxt;
    stop_y_r      <= stop_y_nxt;
    decision_r    <= decision_nxt;
    delta_major_r <= delta_major_nxt;
    delta_minor_r <= delta_minor_nxt;
    steep_r       <= steep_nxt;
    x_backward_r  <= x_backward_nxt;
    y_backward_r  <= y_backward_nxt;
  end

`ifndef SYNTH
  // Line ends only on an emitted last pixel
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(go && res_valid && res.last_pixel))
    else $error("line went idle without a last pixel");

  // A pixel that is not last leaves the line running
  a_not_last_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go && res_valid && !res.last_pixel |=> busy_r)
    else $error("line went idle before its last pixel");

  // Minor delta never exceeds major delta while drawing
  a_delta_order: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> delta_minor_r <= delta_major_r)
    else $error("minor delta larger than major delta");
`endif

endmodule
